>>> rtl/core/scfr_pkg.sv
// ----------------------------------------------------------------------------
// scfr_pkg
// shared types and constants of the sum checked frame receiver
// ----------------------------------------------------------------------------
`default_nettype none

package scfr_pkg;

  localparam logic [7:0] HEADER_BYTE = 8'hA5;
  localparam logic [7:0] TAIL_BYTE   = 8'h5A;

  localparam int CAPTURE_DEPTH = 6;
  localparam int CapIdxW       = $clog2(CAPTURE_DEPTH);

  localparam logic [1:0] PH_HUNT    = 2'd0;
  localparam logic [1:0] PH_PAYLOAD = 2'd1;
  localparam logic [1:0] PH_CHECK   = 2'd2;
  localparam logic [1:0] PH_TAIL    = 2'd3;

  typedef struct packed {
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] vel_omega;
  } scfr_vel_t;

  typedef struct packed {
    logic      hit;
    scfr_vel_t vel;
  } scfr_frame_t;

endpackage

`default_nettype wire

>>> rtl/core/scfr_byte_if.sv
// ----------------------------------------------------------------------------
// scfr_byte_if
// valid/ready channel carrying one received byte per word
// ----------------------------------------------------------------------------
`default_nettype none

interface scfr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

>>> rtl/core/scfr_vel_if.sv
// ----------------------------------------------------------------------------
// scfr_vel_if
// valid/ready channel carrying one decoded velocity word
// ----------------------------------------------------------------------------
`default_nettype none

interface scfr_vel_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] vel_x;
  logic signed [15:0] vel_y;
  logic signed [15:0] vel_omega;

  modport source (output valid, output vel_x, output vel_y, output vel_omega, input ready);
  modport sink (input valid, input vel_x, input vel_y, input vel_omega, output ready);
endinterface

`default_nettype wire

>>> rtl/core/scfr_parser.sv
// ----------------------------------------------------------------------------
// scfr_parser
// frame state machine: header hunt, payload sum and capture, checksum, tail
// ----------------------------------------------------------------------------
`default_nettype none

module scfr_parser import scfr_pkg::*; #(
  parameter int PAYLOAD_LEN = 6
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic [7:0]  byte_i,
  output scfr_frame_t frame_o
);

  localparam int CntW = $clog2(PAYLOAD_LEN + 1);

  logic [1:0]      phase_q, phase_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [7:0]      sum_q, sum_d;
  logic [7:0]      cap_q [CAPTURE_DEPTH];
  logic [CntW-1:0] cnt_inc;
  logic            cap_we;

  assign cnt_inc = cnt_q + 1'b1;
  assign cap_we  = step_i && (phase_q == PH_PAYLOAD) && (cnt_q < CntW'(CAPTURE_DEPTH));

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    sum_d   = sum_q;
    unique case (phase_q)
      PH_HUNT: begin
        if (byte_i == HEADER_BYTE) begin
          cnt_d   = '0;
          sum_d   = '0;
          phase_d = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        sum_d = sum_q + byte_i;
        cnt_d = cnt_inc;
        if (cnt_inc >= CntW'(PAYLOAD_LEN)) begin
          phase_d = PH_CHECK;
        end
      end
      PH_CHECK: begin
        phase_d = (byte_i == sum_q) ? PH_TAIL : PH_HUNT;
      end
      PH_TAIL: begin
        phase_d = PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      cnt_q   <= '0;
      sum_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      sum_q   <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cap_we) begin
      cap_q[cnt_q[CapIdxW-1:0]] <= byte_i;
    end
  end

  assign frame_o.hit           = (phase_q == PH_TAIL) && (byte_i == TAIL_BYTE);
  assign frame_o.vel.vel_x     = {cap_q[1], cap_q[0]};
  assign frame_o.vel.vel_y     = {cap_q[3], cap_q[2]};
  assign frame_o.vel.vel_omega = {cap_q[5], cap_q[4]};

endmodule

`default_nettype wire

>>> rtl/core/sum_checked_frame_receiver.sv
// ----------------------------------------------------------------------------
// sum_checked_frame_receiver
// a velocity word is registered as its tail word makes its single parser pass
// throughput: one byte word per cycle unless a tail word meets a busy output
// the input and result registers let a byte enter while a result waits
// reset clears the parser to header hunt and empties both registers
// ----------------------------------------------------------------------------
`default_nettype none

module sum_checked_frame_receiver import scfr_pkg::*; #(
  parameter int PAYLOAD_LEN = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  scfr_byte_if.sink         rx_i,
  scfr_vel_if.source        vel_o
);

  logic        byte_vld_q;
  logic [7:0]  byte_q;
  logic        out_vld_q;
  scfr_vel_t   vel_q;
  scfr_frame_t frame;
  logic        out_free;
  logic        advance;
  logic        step;
  logic        rx_fire;

  assign out_free   = !out_vld_q || vel_o.ready;
  assign advance    = !frame.hit || out_free;
  assign step       = byte_vld_q && advance;
  assign rx_i.ready = !byte_vld_q || advance;
  assign rx_fire    = rx_i.valid && rx_i.ready;

  scfr_parser #(
    .PAYLOAD_LEN (PAYLOAD_LEN)
  ) u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .byte_i  (byte_q),
    .frame_o (frame)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (rx_fire) begin
        byte_vld_q <= 1'b1;
      end else if (step) begin
        byte_vld_q <= 1'b0;
      end
      if (step && frame.hit) begin
        out_vld_q <= 1'b1;
      end else if (vel_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_fire) begin
      byte_q <= rx_i.rx_byte;
    end
    if (step && frame.hit) begin
      vel_q <= frame.vel;
    end
  end

  assign vel_o.valid     = out_vld_q;
  assign vel_o.vel_x     = vel_q.vel_x;
  assign vel_o.vel_y     = vel_q.vel_y;
  assign vel_o.vel_omega = vel_q.vel_omega;

endmodule

`default_nettype wire

>>> tb/sum_checked_frame_receiver_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sum_checked_frame_receiver_tb
// self-checking bench for the header/checksum/tail frame receiver
// byte words are streamed with random gaps and the velocity words are checked
// against a cycle-free parser kept in the bench, including one long sink stall
// ----------------------------------------------------------------------------

module sum_checked_frame_receiver_tb import scfr_pkg::*;;

  localparam int PAYLOAD_LEN = 6;
  localparam int RANDOM_BYTES = 550;
  localparam int HOLD_AT = 12;
  localparam int HOLD_CYCLES = 150;
  localparam int DRAIN_CYCLES = 20;

  typedef logic [7:0] payload_t [PAYLOAD_LEN];

  logic clk_i = 1'b0;
  logic rst_ni;

  scfr_byte_if rx_if ();
  scfr_vel_if  vel_if ();

  sum_checked_frame_receiver #(
    .PAYLOAD_LEN (PAYLOAD_LEN)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .vel_o  (vel_if)
  );

  always #6 clk_i = ~clk_i;

  logic [7:0] byte_q [$];
  scfr_vel_t  exp_vel_q [$];
  int         err_cnt = 0;

  // parser state mirrored in the bench
  logic [1:0] frm_phase = PH_HUNT;
  logic [6:0] frm_count = '0;
  logic [7:0] frm_sum = '0;
  logic [7:0] frm_bytes [CAPTURE_DEPTH];

  int unsigned src_gap;
  bit          src_steady;
  int unsigned snk_gap;
  int unsigned snk_draw;
  bit          snk_steady;
  int unsigned hold_left;
  bit          vel_hold;
  bit          hold_done;
  int unsigned vel_seen;

  function automatic void parse_rx_byte(input logic [7:0] b);
    scfr_vel_t v;
    case (frm_phase)
      PH_HUNT: begin
        if (b == HEADER_BYTE) begin
          frm_count = '0;
          frm_sum   = '0;
          frm_phase = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        if (frm_count < CAPTURE_DEPTH) frm_bytes[frm_count[CapIdxW-1:0]] = b;
        frm_sum   = frm_sum + b;
        frm_count = frm_count + 7'd1;
        if (frm_count >= PAYLOAD_LEN) frm_phase = PH_CHECK;
      end
      PH_CHECK: begin
        frm_phase = (b == frm_sum) ? PH_TAIL : PH_HUNT;
      end
      default: begin
        if (b == TAIL_BYTE) begin
          v.vel_x     = {frm_bytes[1], frm_bytes[0]};
          v.vel_y     = {frm_bytes[3], frm_bytes[2]};
          v.vel_omega = {frm_bytes[5], frm_bytes[4]};
          exp_vel_q.push_back(v);
        end
        frm_phase = PH_HUNT;
      end
    endcase
  endfunction

  function automatic logic [7:0] payload_sum(input payload_t p);
    logic [7:0] s;
    s = '0;
    foreach (p[i]) s = s + p[i];
    return s;
  endfunction

  function automatic logic [7:0] pick_byte();
    if ($urandom_range(0, 4) != 0) return 8'($urandom_range(0, 255));
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      4: return HEADER_BYTE;
      default: return TAIL_BYTE;
    endcase
  endfunction

  task automatic push_frame(input payload_t p, input logic [7:0] chk, input logic [7:0] tail);
    byte_q.push_back(HEADER_BYTE);
    foreach (p[i]) byte_q.push_back(p[i]);
    byte_q.push_back(chk);
    byte_q.push_back(tail);
  endtask

  task automatic check_velocity();
    scfr_vel_t exp_v;
    if (exp_vel_q.size() == 0) begin
      $error("unexpected velocity word: vel_x %0d vel_y %0d vel_omega %0d",
             vel_if.vel_x, vel_if.vel_y, vel_if.vel_omega);
      err_cnt++;
    end else begin
      exp_v = exp_vel_q.pop_front();
      if (vel_if.vel_x !== exp_v.vel_x) begin
        $error("vel_x mismatch: expected %0d, got %0d", exp_v.vel_x, vel_if.vel_x);
        err_cnt++;
      end
      if (vel_if.vel_y !== exp_v.vel_y) begin
        $error("vel_y mismatch: expected %0d, got %0d", exp_v.vel_y, vel_if.vel_y);
        err_cnt++;
      end
      if (vel_if.vel_omega !== exp_v.vel_omega) begin
        $error("vel_omega mismatch: expected %0d, got %0d", exp_v.vel_omega, vel_if.vel_omega);
        err_cnt++;
      end
    end
  endtask

  // byte word driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_if.valid   <= 1'b0;
      rx_if.rx_byte <= '0;
      src_gap       <= 0;
      src_steady    <= 1'b0;
    end else begin
      if (rx_if.valid && rx_if.ready) parse_rx_byte(rx_if.rx_byte);
      if (!rx_if.valid || rx_if.ready) begin
        if (src_gap != 0) begin
          rx_if.valid <= 1'b0;
          src_gap     <= src_gap - 1;
        end else if (byte_q.size() != 0) begin
          rx_if.valid   <= 1'b1;
          rx_if.rx_byte <= byte_q.pop_front();
          src_gap       <= (src_steady || vel_hold) ? 0 : $urandom_range(0, 12);
        end else begin
          rx_if.valid <= 1'b0;
        end
        if ($urandom_range(0, 49) == 0) src_steady <= !src_steady;
      end
    end
  end

  // velocity word monitor and sink
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vel_if.ready <= 1'b0;
      snk_gap      <= 0;
      snk_steady   <= 1'b0;
      hold_left    <= 0;
      vel_hold     <= 1'b0;
      hold_done    <= 1'b0;
      vel_seen     <= 0;
    end else begin
      if (vel_if.valid && vel_if.ready) begin
        check_velocity();
        vel_seen <= vel_seen + 1;
      end
      if (vel_seen == HOLD_AT && !hold_done) begin
        // long hold-off so the receiver backs up into the byte side
        hold_done    <= 1'b1;
        vel_hold     <= 1'b1;
        hold_left    <= HOLD_CYCLES;
        vel_if.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left    <= hold_left - 1;
        vel_if.ready <= (hold_left == 1);
        if (hold_left == 1) vel_hold <= 1'b0;
      end else if (snk_gap != 0) begin
        snk_gap      <= snk_gap - 1;
        vel_if.ready <= (snk_gap == 1);
      end else if (vel_if.valid && vel_if.ready) begin
        snk_draw     = snk_steady ? 0 : $urandom_range(0, 12);
        snk_gap      <= snk_draw;
        vel_if.ready <= (snk_draw == 0);
        if ($urandom_range(0, 9) == 0) snk_steady <= !snk_steady;
      end else begin
        vel_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    payload_t   p;
    int         dir_len;
    int         k;
    logic [7:0] t;

    rst_ni          = 1'b0;

    // noise while hunting
    byte_q.push_back(8'h00);
    byte_q.push_back(8'hFF);
    // signed extremes, header and tail values inside the payload
    p = '{8'h00, 8'h80, 8'hFF, 8'h7F, HEADER_BYTE, TAIL_BYTE};
    push_frame(p, payload_sum(p), TAIL_BYTE);
    // bad checksum that looks like a header is consumed, not reparsed
    p = '{8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06};
    byte_q.push_back(HEADER_BYTE);
    foreach (p[i]) byte_q.push_back(p[i]);
    byte_q.push_back(HEADER_BYTE);
    // bad tail that looks like a header
    p = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    push_frame(p, payload_sum(p), HEADER_BYTE);
    dir_len = byte_q.size();

    while (byte_q.size() < dir_len + RANDOM_BYTES) begin
      foreach (p[i]) p[i] = pick_byte();
      k = $urandom_range(0, 99);
      if (k < 70) begin
        push_frame(p, payload_sum(p), TAIL_BYTE);
      end else if (k < 80) begin
        push_frame(p, payload_sum(p) ^ 8'($urandom_range(1, 255)), TAIL_BYTE);
      end else if (k < 88) begin
        t = 8'($urandom_range(0, 255));
        if (t == TAIL_BYTE) t = ~t;
        push_frame(p, payload_sum(p), t);
      end else if (k < 95) begin
        repeat ($urandom_range(1, 4)) byte_q.push_back(pick_byte());
      end else begin
        // frame cut short, the next header lands inside its payload
        byte_q.push_back(HEADER_BYTE);
        repeat ($urandom_range(1, PAYLOAD_LEN)) byte_q.push_back(pick_byte());
      end
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    @(posedge clk_i);
    while (byte_q.size() != 0 || rx_if.valid || exp_vel_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
